>>> sv/pixel_format_unpacker_macros.svh
// Assertion macros for the pixel format unpacker.
`ifndef PIXEL_FORMAT_UNPACKER_MACROS_SVH
`define PIXEL_FORMAT_UNPACKER_MACROS_SVH

// Property checked on every rising clock edge, held off while in reset.
`define PFU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define PFU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> sv/pfu_pkg.sv
package pfu_pkg;

    localparam int CFG_W = 4;

    // pixel format codes
    localparam logic [CFG_W-1:0] FMT_565   = 4'd0;
    localparam logic [CFG_W-1:0] FMT_4444  = 4'd1;
    localparam logic [CFG_W-1:0] FMT_6666  = 4'd2;
    localparam logic [CFG_W-1:0] FMT_8565  = 4'd3;
    localparam logic [CFG_W-1:0] FMT_888   = 4'd4;
    localparam logic [CFG_W-1:0] FMT_8888  = 4'd5;
    localparam logic [CFG_W-1:0] FMT_GRAY  = 4'd6;
    localparam logic [CFG_W-1:0] FMT_MONO  = 4'd7;

    localparam logic [7:0] OPAQUE = 8'd255;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    typedef struct packed {
        logic [7:0] octet_0;
        logic [7:0] octet_1;
        logic [7:0] octet_2;
        logic [7:0] octet_3;
        logic [2:0] bit_index;
    } pfu_pixel_t;

    typedef struct packed {
        logic [7:0]  alpha_8;
        logic [4:0]  alpha_5;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] rgb565;
        logic        supported;
    } pfu_result_t;

    // handshake between the input stage and the result stage
    typedef struct packed {
        logic valid;
        logic ready;
    } pfu_hs_t;

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

endpackage

>>> sv/pfu_decode.sv
module pfu_decode (
    input  logic [pfu_pkg::CFG_W-1:0] pixel_format,
    input  pfu_pkg::pfu_pixel_t       pix,
    output pfu_pkg::pfu_result_t      res
);
    import pfu_pkg::*;

    logic [7:0] a, r, g, b;
    logic       ok;
    logic       mono_bit;

    assign mono_bit = pix.octet_0[~pix.bit_index];

    always_comb begin
        a  = OPAQUE;
        r  = '0;
        g  = '0;
        b  = '0;
        ok = 1'b1;
        case (pixel_format)
            FMT_565: begin
                r = widen5(pix.octet_0[7:3]);
                g = widen6({pix.octet_0[2:0], pix.octet_1[7:5]});
                b = widen5(pix.octet_1[4:0]);
            end
            FMT_4444: begin
                a = widen4(pix.octet_0[7:4]);
                r = widen4(pix.octet_0[3:0]);
                g = widen4(pix.octet_1[7:4]);
                b = widen4(pix.octet_1[3:0]);
            end
            FMT_6666: begin
                a = widen6(pix.octet_0[7:2]);
                r = widen6({pix.octet_0[1:0], pix.octet_1[7:4]});
                g = widen6({pix.octet_1[3:0], pix.octet_2[7:6]});
                b = widen6(pix.octet_2[5:0]);
            end
            FMT_8565: begin
                a = pix.octet_0;
                r = widen5(pix.octet_1[7:3]);
                g = widen6({pix.octet_1[2:0], pix.octet_2[7:5]});
                b = widen5(pix.octet_2[4:0]);
            end
            FMT_888: begin
                r = pix.octet_0;
                g = pix.octet_1;
                b = pix.octet_2;
            end
            FMT_8888: begin
                a = pix.octet_0;
                r = pix.octet_1;
                g = pix.octet_2;
                b = pix.octet_3;
            end
            FMT_GRAY: begin
                r = pix.octet_0;
                g = pix.octet_0;
                b = pix.octet_0;
            end
            FMT_MONO: begin
                r = {8{mono_bit}};
                g = r;
                b = r;
            end
            default: begin
                // indexed, unknown and unassigned codes: all zero
                ok = 1'b0;
                a  = '0;
            end
        endcase
    end

    // alpha is already zero when unsupported, so the narrowing needs no gating
    assign res.alpha_8   = a;
    assign res.alpha_5   = a[7:3];
    assign res.red       = r;
    assign res.green     = g;
    assign res.blue      = b;
    assign res.rgb565    = {r[7:3], g[7:2], b[7:3]};
    assign res.supported = ok;

endmodule

>>> sv/pfu_out_reg.sv
module pfu_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pfu_pkg::pfu_result_t res,
    input  logic                 up_valid,
    output logic                 up_ready,
    output pfu_pkg::pfu_result_t out,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import pfu_pkg::*;

    logic        valid_reg, valid_next;
    pfu_result_t res_reg;
    logic        load;

    assign up_ready   = !valid_reg || out_ready;
    assign load       = up_valid && up_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign out       = res_reg;
    assign out_valid = valid_reg;

endmodule

>>> sv/pixel_format_unpacker.sv
// Pixel format unpacker. Each input beat carries the raw octets of one
// stored pixel (octet_0 is the most significant) and, for 1-bit mono, the
// bit position within octet_0 (0 = leftmost). Under the format held in the
// configuration register (0=565, 1=4444, 2=6666, 3=8565, 4=888, 5=8888,
// 6=gray, 7=mono, 8 and up unsupported) the pixel comes out as 8-bit alpha,
// red, green and blue widened by bit replication, an RGB565 word and a 5-bit
// alpha formed by truncation, and a supported flag. Formats without alpha
// report 255; unsupported codes give an all-zero result with the flag clear.
// Throughput is one pixel per clock while m_tready is high; each pixel
// passes the input register, then is decoded into the result register.
// A stage holds its beat while the next is full, so a new pixel enters an
// empty input register while a finished one waits for m_tready. Write the
// format only while no beats are in flight; the register resets to 565.
module pixel_format_unpacker (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write: format code
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pfu_pkg::CFG_W-1:0]      cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] octet_0, [15:8] octet_1, [23:16] octet_2, [31:24] octet_3,
    // [34:32] bit_index, [39:35] zero
    input  logic [pfu_pkg::S_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] alpha_8, [12:8] alpha_5, [20:13] red, [28:21] green,
    // [36:29] blue, [52:37] rgb565, [55:53] zero
    output logic [pfu_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] supported
    output logic                           m_tuser
);
    import pfu_pkg::*;

    `include "pixel_format_unpacker_macros.svh"

    logic [CFG_W-1:0] fmt_reg;

    // Stage 1: input register
    logic       in_valid_reg, in_valid_next;
    pfu_pixel_t pix_reg;
    logic       dec_valid;
    logic       dec_ready;
    logic       in_load;

    pfu_result_t dec_res;
    pfu_result_t out_res;

    // format register; always ready, the user must write it only while idle (not enforced here)
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_565;
        end else if (cfg_valid) begin
            fmt_reg <= cfg_data;
        end
    end

    // input stage advances whenever the result stage can take its beat
    assign dec_valid     = in_valid_reg;
    assign s_tready      = !in_valid_reg || dec_ready;
    assign in_load       = s_tvalid && s_tready;
    assign in_valid_next = in_load || (in_valid_reg && !dec_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            pix_reg.octet_0   <= s_tdata[7:0];
            pix_reg.octet_1   <= s_tdata[15:8];
            pix_reg.octet_2   <= s_tdata[23:16];
            pix_reg.octet_3   <= s_tdata[31:24];
            pix_reg.bit_index <= s_tdata[34:32];
        end
    end

    // Stage 2: decode straight into the result register
    pfu_decode u_decode (
        .pixel_format (fmt_reg),
        .pix          (pix_reg),
        .res          (dec_res)
    );

    pfu_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (dec_res),
        .up_valid  (dec_valid),
        .up_ready  (dec_ready),
        .out       (out_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'b000, out_res.rgb565, out_res.blue, out_res.green,
                      out_res.red, out_res.alpha_5, out_res.alpha_8};
    assign m_tuser = out_res.supported;

    // an accepted pixel always lands in the input register
    `PFU_ASSERT(a_in_load, s_tvalid && s_tready |=> in_valid_reg, "input beat lost")
    // unsupported formats give an all-zero result
    `PFU_ASSERT(a_unsup_zero, m_tvalid && !m_tuser |-> m_tdata == '0, "unsupported result not zero")
    // rgb565 and alpha_5 are truncations of the 8-bit channels
    `PFU_ASSERT(a_rgb565, m_tvalid |-> m_tdata[52:37] == {m_tdata[20:16], m_tdata[28:23], m_tdata[36:32]}, "rgb565 mismatch")
    `PFU_ASSERT(a_alpha5, m_tvalid |-> m_tdata[12:8] == m_tdata[7:3], "alpha_5 mismatch")
    // no result beat while in reset
    `PFU_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid && !in_valid_reg, "valid after reset")

endmodule
